// ===== sv/sulk_pkg.sv =====
// ============================================================================
// sulk_pkg: shared types and constants for the sorted unique key list
// Key format, action and status codes, cell control bundle and FSM states.
// ============================================================================
package sulk_pkg;

    localparam int CAPACITY     = 64;
    localparam int KEY_WIDTH    = 32;

    localparam int ACTION_WIDTH = 3;
    localparam int KEY_FIELD_W  = 32;
    localparam int RANK_WIDTH   = 6;
    localparam int STATUS_WIDTH = 2;
    localparam int COUNT_WIDTH  = 7;

    localparam int IN_BITS      = ACTION_WIDTH + KEY_FIELD_W + RANK_WIDTH;
    localparam int OUT_BITS     = STATUS_WIDTH + KEY_FIELD_W + COUNT_WIDTH;
    localparam int IN_TDATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    // count holds 0..CAPACITY, a cell index 0..CAPACITY-1
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int RK_W         = (CNT_W > RANK_WIDTH) ? CNT_W : RANK_WIDTH;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [CNT_W-1:0]            cnt_t;

    typedef enum logic [ACTION_WIDTH-1:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_READ   = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_DONE  = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic cmp;   // latch compare flags against the broadcast key
        logic ins;   // open a slot at the insert point
        logic rem;   // close the slot of the matching key
    } sulk_ctrl_t;

    // take the low KEY_WIDTH bits of the key field, sign-extending if wider
    function automatic key_t key_from_field(input logic [KEY_FIELD_W-1:0] f);
        key_t k;
        for (int i = 0; i < KEY_WIDTH; i++) begin
            k[i] = (i < KEY_FIELD_W) ? f[i] : f[KEY_FIELD_W-1];
        end
        return k;
    endfunction

    // sign-extend or cut a stored key to the key field width
    function automatic logic [KEY_FIELD_W-1:0] key_to_field(input key_t k);
        logic [KEY_FIELD_W-1:0] f;
        for (int i = 0; i < KEY_FIELD_W; i++) begin
            f[i] = (i < KEY_WIDTH) ? k[i] : k[KEY_WIDTH-1];
        end
        return f;
    endfunction

endpackage

// ===== sv/sulk_cell.sv =====
// ============================================================================
// sulk_cell: one slot of the sorted key chain
// Holds one key, compares it with the broadcast key and shifts with its
// neighbors on insert and remove.
// ============================================================================
module sulk_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  sulk_pkg::sulk_ctrl_t ctrl,
    input  sulk_pkg::key_t      bcast_key,
    input  logic                occupied,
    input  sulk_pkg::key_t      left_key,
    input  logic                left_lt,
    input  sulk_pkg::key_t      right_key,
    output sulk_pkg::key_t      key,
    output logic                lt,
    output logic                eq
);
    import sulk_pkg::*;

    key_t key_reg;
    key_t key_next;
    logic lt_reg;
    logic eq_reg;

    // hold below the insert/remove point, shift above it
    always_comb
    begin
        key_next = key_reg;
        if (ctrl.ins && !lt_reg) begin
            key_next = left_lt ? bcast_key : left_key;
        end else if (ctrl.rem && !lt_reg) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (ctrl.cmp) begin
            lt_reg <= occupied && (key_reg < bcast_key);
            eq_reg <= occupied && (key_reg == bcast_key);
        end
    end

    assign key = key_reg;
    assign lt  = lt_reg;
    assign eq  = eq_reg;

endmodule

// ===== sv/sorted_unique_key_list.sv =====
// ============================================================================
// sorted_unique_key_list: ordered set of distinct signed keys
// A chain of key cells kept in ascending order with insert, remove, find,
// read-at-rank and clear requests.
// ============================================================================
// Usage:
//   Requests enter on the s_* stream, one beat per request; every request
//   returns exactly one result beat on the m_* stream with a status, the key
//   read at a rank (zero otherwise) and the number of keys held afterward.
//   At the accept edge every cell compares its key with the request key and
//   latches less-than/equal flags; in the execute cycle the flags are
//   reduced (found, insert point), the cells shift left or right in one
//   step and the result beat is loaded. A new request is taken only after
//   the previous one has executed; s_tready is low during the execute cycle.
//   The result sits in an output register, so the next request is accepted
//   while the previous result still waits; if the receiver stalls with a
//   result pending, the execute cycle holds until m_tready frees the
//   register. Reset empties the set (count zero) and drops any pending
//   result; the cell contents are not cleared and are never read beyond
//   the count.
// ============================================================================
module sorted_unique_key_list
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action [2:0], key [34:3], rank [40:35], zero fill above
    input  logic [sulk_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [1:0], key_out [33:2], count [40:34], zero fill above
    output logic [sulk_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import sulk_pkg::*;

    localparam int KEY_LO  = ACTION_WIDTH;
    localparam int RANK_LO = ACTION_WIDTH + KEY_FIELD_W;

    state_t                 state_reg;
    state_t                 state_next;

    logic [ACTION_WIDTH-1:0] action_reg;
    key_t                   key_reg;
    logic [RANK_WIDTH-1:0]  rank_reg;
    cnt_t                   count_reg;
    cnt_t                   count_next;

    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;

    logic                   in_fire;
    logic                   out_load;
    key_t                   in_key;
    key_t                   bcast_key;
    sulk_ctrl_t             ctrl;

    key_t                   cell_key [CAPACITY];
    logic [CAPACITY-1:0]    lt_vec;
    logic [CAPACITY-1:0]    eq_vec;

    logic                   found;
    logic                   full;
    logic [RK_W-1:0]        rank_ext;
    logic [RK_W-1:0]        count_ext;
    logic                   rank_ok;
    status_t                status;
    logic [KEY_FIELD_W-1:0] key_out;

    assign in_key  = key_from_field(s_tdata[KEY_LO +: KEY_FIELD_W]);
    assign in_fire = s_tvalid && s_tready;

    // ---------------------------------------------------------------- FSM
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_fire) state_next = S_EXEC;
            S_EXEC: if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: s_tready = 1'b1;
            // execute only once the output register is free
            S_EXEC: out_load = !m_tvalid_reg || m_tready;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // latch the request fields at the accept edge
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            action_reg <= s_tdata[ACTION_WIDTH-1:0];
            key_reg    <= in_key;
            rank_reg   <= s_tdata[RANK_LO +: RANK_WIDTH];
        end
        m_tdata_reg <= m_tdata_next;
    end

    // ---------------------------------------------------------- cell chain
    // compare against the incoming key, shift with the latched one
    assign bcast_key = (state_reg == S_IDLE) ? in_key : key_reg;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            localparam cnt_t IDX = CNT_W'(g);
            key_t lkey;
            logic llt;
            key_t rkey;

            if (g == 0) begin : g_first
                assign lkey = bcast_key;
                assign llt  = 1'b1;
            end else begin : g_mid
                assign lkey = cell_key[g-1];
                assign llt  = lt_vec[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign rkey = cell_key[g];
            end else begin : g_inner
                assign rkey = cell_key[g+1];
            end

            sulk_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .bcast_key (bcast_key),
                .occupied  (IDX < count_reg),
                .left_key  (lkey),
                .left_lt   (llt),
                .right_key (rkey),
                .key       (cell_key[g]),
                .lt        (lt_vec[g]),
                .eq        (eq_vec[g])
            );
        end
    endgenerate

    // ----------------------------------------------------------- execute
    assign found     = |eq_vec;
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign rank_ext  = RK_W'(rank_reg);
    assign count_ext = RK_W'(count_reg);
    assign rank_ok   = rank_ext < count_ext;

    always_comb
    begin
        ctrl       = '0;
        ctrl.cmp   = in_fire;
        count_next = count_reg;
        status     = ST_DONE;
        key_out    = '0;
        unique case (action_reg)
            ACT_INSERT:
            begin
                if (found) begin
                    status = ST_MISS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.ins   = out_load;
                    count_next = out_load ? count_reg + 1'b1 : count_reg;
                end
            end
            ACT_REMOVE:
            begin
                if (found) begin
                    ctrl.rem   = out_load;
                    count_next = out_load ? count_reg - 1'b1 : count_reg;
                end else begin
                    status = ST_MISS;
                end
            end
            ACT_FIND:
            begin
                if (!found) status = ST_MISS;
            end
            ACT_READ:
            begin
                if (rank_ok) begin
                    key_out = key_to_field(cell_key[rank_ext[IDX_W-1:0]]);
                end else begin
                    status = ST_RANGE;
                end
            end
            ACT_CLEAR:
            begin
                count_next = out_load ? '0 : count_reg;
            end
            default: status = ST_DONE;   // unused codes: no operation
        endcase
    end

    // ------------------------------------------------------ output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_TDATA_W'({COUNT_WIDTH'(count_next), key_out, status});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // --------------------------------------------------------- assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("key count above capacity");

    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    a_sorted_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |-> ((lt_vec & (lt_vec + 1'b1)) == '0))
        else $error("less-than flags do not form a prefix");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.ins |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the count");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_EXEC) && !s_tready)
        else $error("accepted request not executed");

endmodule
